// ===== src/sia_pkg.sv =====
// package: types, codes and the per-stage step function of the signed integer alu
`default_nettype none
package sia_pkg;

  localparam int DATA_WIDTH = 32;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_REM = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DIV0  = 2'd1;
  localparam logic [1:0] ST_MOD0  = 2'd2;
  localparam logic [1:0] ST_UNSUP = 2'd3;

  typedef struct packed {
    logic [2:0]                   mode;
    logic signed [DATA_WIDTH-1:0] left_operand;
    logic signed [DATA_WIDTH-1:0] right_operand;
  } alu_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] result_value;
    logic [1:0]                   status;
  } alu_out_t;

  typedef struct packed {
    logic [2:0]            mode;
    logic [1:0]            status;
    logic                  neg_q;
    logic                  neg_r;
    logic [DATA_WIDTH-1:0] sum;
    logic [DATA_WIDTH-1:0] rem;
    logic [DATA_WIDTH-1:0] quo;
    logic [DATA_WIDTH-1:0] dvs;
    logic [DATA_WIDTH-1:0] acc;
    logic [DATA_WIDTH-1:0] mcand;
    logic [DATA_WIDTH-1:0] mplier;
  } stage_t;

  // one restoring divide step and one shift-add multiply step
  function automatic stage_t stage_step(input stage_t s);
    stage_t              o;
    logic [DATA_WIDTH+1:0] diff;
    o    = s;
    diff = {1'b0, s.rem, s.quo[DATA_WIDTH-1]} - {2'b00, s.dvs};
    if (!diff[DATA_WIDTH+1]) begin
      o.rem = diff[DATA_WIDTH-1:0];
      o.quo = {s.quo[DATA_WIDTH-2:0], 1'b1};
    end else begin
      o.rem = {s.rem[DATA_WIDTH-2:0], s.quo[DATA_WIDTH-1]};
      o.quo = {s.quo[DATA_WIDTH-2:0], 1'b0};
    end
    if (s.mplier[0]) begin
      o.acc = s.acc + s.mcand;
    end
    o.mcand  = {s.mcand[DATA_WIDTH-2:0], 1'b0};
    o.mplier = {1'b0, s.mplier[DATA_WIDTH-1:1]};
    return o;
  endfunction

endpackage
`default_nettype wire

// ===== src/signed_int_alu_with_divide.sv =====
// Signed integer ALU: add, subtract, multiply, divide and remainder on
// two's-complement words of sia_pkg::DATA_WIDTH bits.
// Input channel in_valid/in_ready carries one operation per transaction
// (mode, left_operand, right_operand); output channel out_valid/out_ready
// returns one transaction per input (result_value, status), in order.
// A transaction passes from acceptance to out_valid through one decode stage,
// DATA_WIDTH step stages each doing one restoring divide
// bit and one shift-add multiply bit, and the output register.
// Throughput: one transaction per cycle, sustained while out_ready stays high.
// Divide by zero and remainder by zero return status 1 and 2 with value 0,
// unused modes status 3 with value 0; min / -1 gives min, remainder 0.
// Every stage holds its own valid bit and advances whenever the stage after
// it is empty or moving, so bubbles close up and in_ready stays high while
// the pipeline still has room behind a stalled output.
// When out_ready is low the output register holds its transaction and
// the stages fill up one by one before in_ready falls.
// Reset (rst_n low, synchronous) empties every stage; payload is not cleared.
`default_nettype none
module signed_int_alu_with_divide
  import sia_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire alu_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output alu_out_t      out_data
);

  localparam int W = DATA_WIDTH;

  stage_t         stg_r   [0:W];
  stage_t         dec_nxt;
  stage_t         stg_nxt [1:W];
  logic [W:0]     vld_r;
  logic [W+1:0]   rdy;
  logic           out_valid_r;
  alu_out_t       out_data_r;
  alu_out_t       out_data_nxt;

  logic [W-1:0]   a;
  logic [W-1:0]   b;
  logic           neg_a;
  logic           neg_b;
  logic [W-1:0]   mag_a;
  logic [W-1:0]   mag_b;

  // decode stage
  always_comb begin
    a     = in_data.left_operand;
    b     = in_data.right_operand;
    neg_a = a[W-1];
    neg_b = b[W-1];
    mag_a = neg_a ? (~a + 1'b1) : a;
    mag_b = neg_b ? (~b + 1'b1) : b;
    dec_nxt.mode   = in_data.mode;
    dec_nxt.neg_q  = neg_a ^ neg_b;
    dec_nxt.neg_r  = neg_a;
    dec_nxt.sum    = (in_data.mode == OP_SUB) ? (a - b) : (a + b);
    dec_nxt.rem    = '0;
    dec_nxt.quo    = mag_a;
    dec_nxt.dvs    = mag_b;
    dec_nxt.acc    = '0;
    dec_nxt.mcand  = a;
    dec_nxt.mplier = b;
    case (in_data.mode)
      OP_ADD, OP_SUB, OP_MUL: dec_nxt.status = ST_OK;
      OP_DIV:  dec_nxt.status = (b == '0) ? ST_DIV0 : ST_OK;
      OP_REM:  dec_nxt.status = (b == '0) ? ST_MOD0 : ST_OK;
      default: dec_nxt.status = ST_UNSUP;
    endcase
  end

  always_comb begin
    for (int k = 1; k <= W; k++) begin
      stg_nxt[k] = stage_step(stg_r[k-1]);
    end
  end

  // stage k may load when it is empty or the stage after it moves
  always_comb begin
    rdy[W+1] = !out_valid_r || out_ready;
    for (int k = W; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_comb begin
    out_data_nxt.status = stg_r[W].status;
    case (stg_r[W].mode)
      OP_ADD, OP_SUB: out_data_nxt.result_value = stg_r[W].sum;
      OP_MUL:  out_data_nxt.result_value = stg_r[W].acc;
      OP_DIV:  out_data_nxt.result_value = stg_r[W].neg_q ? (~stg_r[W].quo + 1'b1)
                                                          : stg_r[W].quo;
      OP_REM:  out_data_nxt.result_value = stg_r[W].neg_r ? (~stg_r[W].rem + 1'b1)
                                                          : stg_r[W].rem;
      default: out_data_nxt.result_value = '0;
    endcase
    if (stg_r[W].status != ST_OK) begin
      out_data_nxt.result_value = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k <= W; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
      if (rdy[W+1]) begin
        out_valid_r <= vld_r[W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      stg_r[0] <= dec_nxt;
    end
    for (int k = 1; k <= W; k++) begin
      if (rdy[k] && vld_r[k-1]) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
    if (rdy[W+1] && vld_r[W]) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a failed operation never carries a value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.status != ST_OK) |-> (out_data_r.result_value == '0))
    else $error("non-zero result with error status");

  // a new output transaction comes only from a full last stage
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(vld_r[W]))
    else $error("output transaction without source");

  // last stage holds while the output register is stalled
  a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[W] && !rdy[W+1] |=> vld_r[W] && $stable(stg_r[W]))
    else $error("last stage lost during stall");

endmodule
`default_nettype wire

// ===== bench/tb_signed_int_alu_with_divide.sv =====
// testbench for the signed integer alu: corner cases and random operations against a predictor
`timescale 1ns / 1ps
module tb_signed_int_alu_with_divide
  import sia_pkg::*;
;

  localparam logic [2:0] OP_SPARE5 = 3'd5;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam logic signed [DATA_WIDTH-1:0] WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [DATA_WIDTH-1:0] WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] MINUS_ONE = '1;
  localparam int PIPE_LATENCY = DATA_WIDTH + 2;
  localparam int STALL_LIMIT = 2000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  alu_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  alu_out_t out_data;

  alu_out_t pending_results[$];
  bit       sender_idles;
  bit       receiver_stalls;
  int       ops_sent;
  int       results_checked;
  int       mismatch_count;
  int       stray_results;
  int       zero_divisor_ops;
  int       unsupported_ops;
  int       quiet_cycles;

  signed_int_alu_with_divide u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [DATA_WIDTH-1:0] magnitude_of(input logic [DATA_WIDTH-1:0] v);
    return v[DATA_WIDTH-1] ? ('0 - v) : v;
  endfunction

  function automatic alu_out_t compute_alu_result(input alu_in_t op);
    alu_out_t              res;
    logic [DATA_WIDTH-1:0] a;
    logic [DATA_WIDTH-1:0] b;
    logic [DATA_WIDTH-1:0] mag;
    a = op.left_operand;
    b = op.right_operand;
    res.result_value = '0;
    res.status = ST_OK;
    case (op.mode)
      OP_ADD: res.result_value = a + b;
      OP_SUB: res.result_value = a - b;
      OP_MUL: res.result_value = a * b;
      OP_DIV: begin
        if (b == '0) begin
          res.status = ST_DIV0;
        end else begin
          mag = magnitude_of(a) / magnitude_of(b);
          res.result_value = (a[DATA_WIDTH-1] != b[DATA_WIDTH-1]) ? ('0 - mag) : mag;
        end
      end
      OP_REM: begin
        if (b == '0) begin
          res.status = ST_MOD0;
        end else begin
          mag = magnitude_of(a) % magnitude_of(b);
          res.result_value = a[DATA_WIDTH-1] ? ('0 - mag) : mag;
        end
      end
      default: res.status = ST_UNSUP;
    endcase
    return res;
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] random_operand();
    logic signed [DATA_WIDTH-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = WORD_MIN;
          1: v = WORD_MAX;
          2: v = MINUS_ONE;
          3: v = 1;
          default: v = '0;
        endcase
      end
      1, 2: v = $signed($urandom_range(0, 40)) - 20;
      3: v = $signed($urandom_range(0, 65535)) - 32768;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // drives one transaction from a falling edge and books its expected result on acceptance
  task automatic send_op(input logic [2:0] mode, input logic signed [DATA_WIDTH-1:0] a,
                         input logic signed [DATA_WIDTH-1:0] b);
    alu_in_t  op;
    alu_out_t res;
    op.mode = mode;
    op.left_operand = a;
    op.right_operand = b;
    @(negedge clk);
    while (sender_idles && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (!in_ready);
    res = compute_alu_result(op);
    pending_results.push_back(res);
    ops_sent++;
    if (res.status == ST_DIV0 || res.status == ST_MOD0) zero_divisor_ops++;
    if (res.status == ST_UNSUP) unsupported_ops++;
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_add_sub_wrap();
    send_op(OP_ADD, WORD_MAX, 1);
    send_op(OP_ADD, WORD_MIN, MINUS_ONE);
    send_op(OP_ADD, MINUS_ONE, MINUS_ONE);
    send_op(OP_SUB, WORD_MIN, 1);
    send_op(OP_SUB, '0, WORD_MIN);
  endtask

  task automatic test_multiply_extremes();
    send_op(OP_MUL, WORD_MAX, WORD_MAX);
    send_op(OP_MUL, WORD_MIN, MINUS_ONE);
    send_op(OP_MUL, WORD_MIN, WORD_MIN);
    send_op(OP_MUL, MINUS_ONE, MINUS_ONE);
  endtask

  task automatic test_divide_corners();
    send_op(OP_DIV, 12345, '0);
    send_op(OP_REM, WORD_MIN, '0);
    send_op(OP_DIV, WORD_MIN, MINUS_ONE);
    send_op(OP_REM, WORD_MIN, MINUS_ONE);
    send_op(OP_DIV, 7, -2);
    send_op(OP_DIV, -7, 2);
    send_op(OP_DIV, -7, -2);
    send_op(OP_REM, 7, -2);
    send_op(OP_REM, -7, 2);
    send_op(OP_DIV, WORD_MIN, WORD_MIN);
  endtask

  task automatic test_unsupported_modes();
    send_op(OP_SPARE5, random_operand(), random_operand());
    send_op(OP_SPARE6, WORD_MAX, WORD_MIN);
    send_op(OP_SPARE7, random_operand(), '0);
  endtask

  task automatic test_random_ops(input int count);
    logic [2:0]                   mode;
    logic signed [DATA_WIDTH-1:0] a;
    logic signed [DATA_WIDTH-1:0] b;
    int                           pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 15);
      mode = (pick < 13) ? 3'(pick % 5) : 3'(OP_SPARE5 + (pick - 13));
      a = random_operand();
      b = random_operand();
      if ((mode == OP_DIV || mode == OP_REM) && $urandom_range(0, 11) == 0) b = '0;
      send_op(mode, a, b);
      if (i == count / 2) wait_for_drain();
    end
  endtask

  task automatic test_back_to_back(input int count);
    sender_idles = 1'b0;
    receiver_stalls = 1'b0;
    test_random_ops(count);
    wait_for_drain();
    sender_idles = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  always @(negedge clk) begin
    out_ready <= receiver_stalls ? ($urandom_range(0, 99) >= 16) : 1'b1;
  end

  always @(posedge clk) begin
    alu_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        stray_results++;
        if (mismatch_count + stray_results <= 10)
          $display("unexpected result: value %0d status %0d",
                   out_data.result_value, out_data.status);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_data.result_value !== want.result_value || out_data.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count + stray_results <= 10)
            $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                     want.result_value, want.status, out_data.result_value, out_data.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    sender_idles = 1'b1;
    receiver_stalls = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_add_sub_wrap();
    test_multiply_extremes();
    test_divide_corners();
    test_unsupported_modes();
    wait_for_drain();
    test_random_ops(1100);
    wait_for_drain();
    test_back_to_back(230);

    wait_for_drain();
    repeat (PIPE_LATENCY + 6) @(posedge clk);

    $display("covered %0d operations (%0d zero divisor, %0d unsupported mode), %0d results checked",
             ops_sent, zero_divisor_ops, unsupported_ops, results_checked);
    $display("idle and stall gaps on both channels, plus one back-to-back stretch at full rate");
    if (mismatch_count == 0 && stray_results == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d unexpected, %0d missing",
               mismatch_count, stray_results, pending_results.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/sia_pkg.sv
src/signed_int_alu_with_divide.sv
bench/tb_signed_int_alu_with_divide.sv
